/* sv/sbm_pkg.sv */
// ----------------------------------------------------------------------------
// sbm_pkg: shared types for the sorted button map table
// Beat payloads, entry layout, status codes and the cell command group.
// ----------------------------------------------------------------------------
package sbm_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   typedef enum logic {
      FUNC_SEARCH = 1'b0,
      FUNC_INSERT = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_KEY   = 3'd1,
      STATUS_ZERO_DEST = 3'd2,
      STATUS_BAD_POS   = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_AUTO   = 2'd1,
      MODE_GIVEN  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EVAL   = 2'd1,
      ST_COMMIT = 2'd2
   } state_type;

   typedef struct packed {
      func_type           func;
      logic [30:0]        key;
      logic signed [7:0]  position;
      logic signed [31:0] range_a;
      logic signed [31:0] range_b;
      logic signed [31:0] dest_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        found;
      logic [6:0]  index;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [30:0]        key;
      logic signed [31:0] low;
      logic signed [31:0] high;
      logic signed [31:0] dest;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      mode_type    mode;
      logic [30:0] key;
      logic        cmp_en;
      logic        commit;
   } cell_cmd_type;

endpackage

/* sv/sorted_button_map_table_unit.sv */
// result: the request is registered, compared in eval, and the result beat is registered as commit ends
// a new request can be taken in the commit state of the one before (eval, then commit/shift)
// a stalled result holds the commit cycle until the result register drains
// reset clears the entry count, state and result valid; the stored entries
// keep no reset and are only read below the count
// ----------------------------------------------------------------------------
// sorted_button_map_table_unit: sorted key table built from a chain of cells
// Search returns the first match or insertion point; insert shifts the entries
// at and above the chosen slot up by one and writes the new entry.
// ----------------------------------------------------------------------------
module sorted_button_map_table_unit #(
   parameter int CAPACITY = sbm_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbm_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   sbm_pkg::state_type state_ff, state_in;
   sbm_pkg::req_type   op_ff, op_in;
   logic [CW-1:0]      count_ff, count_in;
   sbm_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               out_free;
   logic               accept;
   logic               cmp_en;
   logic               done;

   sbm_pkg::cell_cmd_type cmd;
   sbm_pkg::entry_type    new_entry;
   sbm_pkg::entry_type    entry_vec [CAPACITY];
   logic [CAPACITY-1:0]   after_vec;
   logic [CAPACITY-1:0]   first_vec;
   logic [CAPACITY-1:0]   hit_vec;
   logic [CAPACITY-1:0]   bad_vec;

   logic               pos_given;
   logic [CW-1:0]      pos_idx;
   logic [CW-1:0]      idx_acc;
   logic [CW-1:0]      slot;
   sbm_pkg::status_type status;
   logic               commit_ok;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbm_pkg::ST_IDLE: begin
            if (accept) state_in = sbm_pkg::ST_EVAL;
         end
         sbm_pkg::ST_EVAL: begin
            state_in = sbm_pkg::ST_COMMIT;
         end
         sbm_pkg::ST_COMMIT: begin
            if (out_free) state_in = accept ? sbm_pkg::ST_EVAL : sbm_pkg::ST_IDLE;
         end
         default: state_in = sbm_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall = 1'b1;
      cmp_en    = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         sbm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         sbm_pkg::ST_EVAL: begin
            cmp_en = 1'b1;
         end
         sbm_pkg::ST_COMMIT: begin
            req_stall = !out_free;
            done      = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign op_in = accept ? req_data : op_ff;

   // a given position is honored only from 0 up to the count
   assign pos_given = !op_ff.position[7] && (32'(op_ff.position[6:0]) <= 32'(count_ff));
   assign pos_idx   = CW'(op_ff.position[6:0]);

   always_comb begin
      cmd.key    = op_ff.key;
      cmd.cmp_en = cmp_en;
      cmd.commit = commit_ok;
      if (op_ff.func == sbm_pkg::FUNC_SEARCH) begin
         cmd.mode = sbm_pkg::MODE_SEARCH;
      end else if (pos_given) begin
         cmd.mode = sbm_pkg::MODE_GIVEN;
      end else begin
         cmd.mode = sbm_pkg::MODE_AUTO;
      end
   end

   always_comb begin
      new_entry.key  = op_ff.key;
      new_entry.dest = op_ff.dest_id;
      if (op_ff.range_a <= op_ff.range_b) begin
         new_entry.low  = op_ff.range_a;
         new_entry.high = op_ff.range_b;
      end else begin
         new_entry.low  = op_ff.range_b;
         new_entry.high = op_ff.range_a;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      sbm_cell #(
         .IDX (g),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .pos        (pos_idx),
         .new_entry  (new_entry),
         .prev_entry (entry_vec[(g == 0) ? 0 : g - 1]),
         .prev_after ((g == 0) ? 1'b0 : after_vec[(g == 0) ? 0 : g - 1]),
         .after      (after_vec[g]),
         .first      (first_vec[g]),
         .hit        (hit_vec[g]),
         .bad        (bad_vec[g]),
         .entry      (entry_vec[g])
      );
   end

   // one-hot boundary to slot number; no boundary means every cell is below
   always_comb begin
      idx_acc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         idx_acc = idx_acc | (first_vec[i] ? CW'(i) : '0);
      end
      slot = (|first_vec) ? idx_acc : count_ff;
   end

   always_comb begin
      priority if (op_ff.func == sbm_pkg::FUNC_SEARCH) begin
         status = sbm_pkg::STATUS_OK;
      end else if (op_ff.key == '0) begin
         status = sbm_pkg::STATUS_BAD_KEY;
      end else if (op_ff.dest_id == '0) begin
         status = sbm_pkg::STATUS_ZERO_DEST;
      end else if (pos_given && (|bad_vec)) begin
         status = sbm_pkg::STATUS_BAD_POS;
      end else if (32'(count_ff) >= CAPACITY) begin
         status = sbm_pkg::STATUS_FULL;
      end else begin
         status = sbm_pkg::STATUS_OK;
      end
   end

   assign commit_ok = done && (op_ff.func == sbm_pkg::FUNC_INSERT) &&
                      (status == sbm_pkg::STATUS_OK);

   always_comb begin
      count_in = count_ff;
      if (commit_ok) count_in = count_ff + CW'(1);
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = status;
         rsp_in.found       = (op_ff.func == sbm_pkg::FUNC_SEARCH) && (|hit_vec);
         rsp_in.entry_count = 7'(count_in);
         if (op_ff.func == sbm_pkg::FUNC_SEARCH || status == sbm_pkg::STATUS_OK) begin
            rsp_in.index = 7'(slot);
         end else begin
            rsp_in.index = '0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbm_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("entry count above capacity");

   a_single_boundary: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbm_pkg::ST_COMMIT) |-> $onehot0(first_vec))
      else $error("more than one boundary cell");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      commit_ok |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("count did not advance on insert");

   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff)
      else $error("finished item gave no result beat");
`endif

endmodule

/* sv/sbm_cell.sv */
// ----------------------------------------------------------------------------
// sbm_cell: one slot of the sorted table
// Holds one entry, registers its compare flags against the broadcast key and
// either takes its lower neighbor's entry or the new entry on commit.
// ----------------------------------------------------------------------------
module sbm_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic                  clock,
   input  sbm_pkg::cell_cmd_type cmd,
   input  logic [CW-1:0]         count,
   input  logic [CW-1:0]         pos,
   input  sbm_pkg::entry_type    new_entry,
   input  sbm_pkg::entry_type    prev_entry,
   input  logic                  prev_after,
   output logic                  after,
   output logic                  first,
   output logic                  hit,
   output logic                  bad,
   output sbm_pkg::entry_type    entry
);

   logic               lt_ff, lt_in;
   logic               le_ff, le_in;
   sbm_pkg::entry_type entry_ff, entry_in;
   logic               occupied;

   assign occupied = CW'(IDX) < count;

   always_comb begin
      lt_in = lt_ff;
      le_in = le_ff;
      if (cmd.cmp_en) begin
         lt_in = occupied && (entry_ff.key < cmd.key);
         le_in = occupied && (entry_ff.key <= cmd.key);
      end
   end

   // after: this slot sits at or above the chosen position
   always_comb begin
      unique case (cmd.mode)
         sbm_pkg::MODE_SEARCH: after = !lt_ff;
         sbm_pkg::MODE_AUTO:   after = !le_ff;
         sbm_pkg::MODE_GIVEN:  after = CW'(IDX) >= pos;
         default:              after = 1'b0;
      endcase
   end

   assign first = after && !prev_after;
   assign hit   = first && le_ff;
   assign bad   = (cmd.mode == sbm_pkg::MODE_GIVEN) &&
                  (((CW'(IDX + 1) == pos) && !le_ff) || ((CW'(IDX) == pos) && lt_ff));

   always_comb begin
      entry_in = entry_ff;
      if (cmd.commit) begin
         if (first) begin
            entry_in = new_entry;
         end else if (prev_after && (CW'(IDX) <= count)) begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      lt_ff    <= lt_in;
      le_ff    <= le_in;
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sorted_button_map_table_unit
// Fills the key table through directed and random inserts and searches.
// The scoreboard keeps its own sorted key list and checks each result beat
// field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import sbm_pkg::*;

   localparam int RANDOM_ITEMS   = 1880;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic calm = 1'b0;
   int   quiet_cycles = 0;

   // ranges and destinations never show up in a result, so only keys are kept
   class map_table_scoreboard;
      logic [30:0] key_tab [CAPACITY_DEFAULT];
      int          fill;
      rsp_type     expected_q [$];
      int          failures;

      function new();
         fill     = 0;
         failures = 0;
      endfunction

      function int first_at_or_above(logic [30:0] k);
         int i;
         for (i = 0; i < fill; i++) begin
            if (key_tab[i] >= k) return i;
         end
         return fill;
      endfunction

      function int first_above(logic [30:0] k);
         int i;
         for (i = 0; i < fill; i++) begin
            if (key_tab[i] > k) return i;
         end
         return fill;
      endfunction

      function rsp_type expected_result(req_type r);
         rsp_type e;
         int      slot;
         int      pos;
         int      i;
         e = '0;
         e.status = STATUS_OK;
         pos = $signed(r.position);
         if (r.func == FUNC_SEARCH) begin
            slot = first_at_or_above(r.key);
            e.found = (slot < fill) && (key_tab[slot] == r.key);
            e.index = 7'(slot);
         end else if (r.key == '0) begin
            e.status = STATUS_BAD_KEY;
         end else if (r.dest_id == '0) begin
            e.status = STATUS_ZERO_DEST;
         end else begin
            if (pos < 0 || pos > fill) begin
               slot = first_above(r.key);
            end else begin
               slot = pos;
               if ((slot > 0 && key_tab[slot - 1] > r.key) ||
                   (slot < fill && key_tab[slot] < r.key)) begin
                  e.status = STATUS_BAD_POS;
               end
            end
            if (e.status == STATUS_OK && fill >= CAPACITY_DEFAULT) begin
               e.status = STATUS_FULL;
            end
            if (e.status == STATUS_OK) begin
               for (i = fill; i > slot; i--) key_tab[i] = key_tab[i - 1];
               key_tab[slot] = r.key;
               fill++;
               e.index = 7'(slot);
            end
         end
         e.entry_count = 7'(fill);
         return e;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(expected_result(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: status %0d index %0d",
                   got.status, got.index);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            failures++;
         end
         if (got.index !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, got.index);
            failures++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   got.entry_count);
            failures++;
         end
      endfunction
   endclass

   map_table_scoreboard sb;

   sorted_button_map_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 14);
   end

   // result checking and the no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_button_map_table_unit test failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic req_type make_req(func_type f, logic [30:0] k,
                                        logic signed [7:0] pos, logic [31:0] ra,
                                        logic [31:0] rb, logic [31:0] dest);
      req_type r;
      r.func     = f;
      r.key      = k;
      r.position = pos;
      r.range_a  = ra;
      r.range_b  = rb;
      r.dest_id  = dest;
      return r;
   endfunction

   function automatic logic [30:0] pick_key();
      case ($urandom_range(19))
         0: return '0;
         1: return '1;
         2, 3: return 31'($urandom);
         4, 5, 6, 7, 8: begin
            if (sb.fill > 0) return sb.key_tab[$urandom_range(sb.fill - 1)];
            return 31'($urandom_range(1, 48));
         end
         default: return 31'($urandom_range(1, 48));
      endcase
   endfunction

   function automatic logic signed [7:0] pick_position(logic [30:0] k);
      int lo_slot;
      int hi_slot;
      lo_slot = sb.first_at_or_above(k);
      hi_slot = sb.first_above(k);
      case ($urandom_range(9))
         0, 1, 2, 3: return -8'sd1;
         4, 5: return 8'($urandom_range(hi_slot, lo_slot));
         6: return 8'($urandom_range(sb.fill));
         7: return 8'(sb.fill + $urandom_range(1, 3));
         8: return 8'(CAPACITY_DEFAULT);
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_dest();
      case ($urandom_range(11))
         0: return '0;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      logic [30:0] k;
      k = pick_key();
      // inserts are spread out so the table fills about a third of the way in
      if ($urandom_range(sb.fill < CAPACITY_DEFAULT ? 7 : 3) == 0) begin
         return make_req(FUNC_INSERT, k, pick_position(k), $urandom, $urandom,
                         pick_dest());
      end
      return make_req(FUNC_SEARCH, k, 8'($urandom), $urandom, $urandom, $urandom);
   endfunction

   task automatic send_beat(input req_type beat);
      while (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(beat);
   endtask

   initial begin
      int n;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table searches at both key extremes
      send_beat(make_req(FUNC_SEARCH, 31'd0, -1, 0, 0, 0));
      send_beat(make_req(FUNC_SEARCH, 31'h7fff_ffff, 0, 0, 0, 0));
      // operand errors and their order
      send_beat(make_req(FUNC_INSERT, 31'd0, -1, 1, 2, 7));
      send_beat(make_req(FUNC_INSERT, 31'd0, -1, 1, 2, 0));
      send_beat(make_req(FUNC_INSERT, 31'd5, -1, 1, 2, 0));
      // swapped range, automatic placement, past-the-end position
      send_beat(make_req(FUNC_INSERT, 31'd5, -1, 100, -100, 7));
      send_beat(make_req(FUNC_INSERT, 31'd5, 64, -5, 5, 8));
      // given positions that break the order
      send_beat(make_req(FUNC_INSERT, 31'd3, 1, 0, 0, 9));
      send_beat(make_req(FUNC_INSERT, 31'd9, 0, 0, 0, 9));
      send_beat(make_req(FUNC_INSERT, 31'd9, 0, 0, 0, 0));
      // given positions that keep the order, then out-of-range positions
      send_beat(make_req(FUNC_INSERT, 31'd3, 0, 0, 0, 10));
      send_beat(make_req(FUNC_INSERT, 31'd5, 1, 0, 0, 11));
      send_beat(make_req(FUNC_INSERT, 31'h7fff_ffff, 4, 32'h7fff_ffff,
                         32'h8000_0000, 32'h8000_0000));
      send_beat(make_req(FUNC_INSERT, 31'd5, -128, 0, 0, -1));
      send_beat(make_req(FUNC_INSERT, 31'd1, 127, 32'h8000_0000, 32'h7fff_ffff,
                         32'h7fff_ffff));
      // searches: hits, misses, extremes
      send_beat(make_req(FUNC_SEARCH, 31'd5, 0, 0, 0, 0));
      send_beat(make_req(FUNC_SEARCH, 31'd4, 0, 0, 0, 0));
      send_beat(make_req(FUNC_SEARCH, 31'd6, 0, 0, 0, 0));
      send_beat(make_req(FUNC_SEARCH, 31'h7fff_ffff, -1, -1, -1, -1));
      send_beat(make_req(FUNC_SEARCH, 31'd0, 127, 0, 0, 0));
      send_beat(make_req(FUNC_SEARCH, 31'h7fff_fffe, 0, 0, 0, 0));

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // a long stretch with neither side idling
         calm <= (n >= 700 && n < 1000);
         send_beat(random_request());
      end
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("sorted_button_map_table_unit test passed");
      end else begin
         $display("sorted_button_map_table_unit test failed");
      end
      $finish;
   end
endmodule

/* files.f */
sv/sbm_pkg.sv
sv/sbm_cell.sv
sv/sorted_button_map_table_unit.sv
tb/testbench.sv
